// ----- rtl/bba_pkg.sv -----
// Shared types and constants for the bitmap block allocator.
// No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_BADOFF = 2'd2;

    localparam logic [7:0] TAG_RESERVED = 8'd5;

    localparam logic CFG_REGION = 1'b0;
    localparam logic CFG_BSIZE  = 1'b1;

    typedef enum logic [1:0] {
        DIV_BYTES_BY_BS = 2'd0,
        DIV_CEIL_RES    = 2'd1,
        DIV_CEIL_NEED   = 2'd2,
        DIV_OFFSET      = 2'd3
    } div_kind_t;

    typedef struct packed {
        logic        start;
        logic [21:0] dividend;
        logic [12:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [21:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/bba_divider.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_divider
    import bba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [21:0] quo_reg, quo_next;
    logic [13:0] rem_reg, rem_next;
    logic [12:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [13:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[12:0], quo_reg[21]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 5'd22;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[20:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[20:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) rsp.done |-> !busy_reg;
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("divider done while busy");

    property p_no_start_busy;
        @(posedge clk) disable iff (!rst_n) busy_reg && cnt_reg != 5'd1 |=> busy_reg;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy) else $error("divider stopped early");

    property p_cnt_zero_idle;
        @(posedge clk) disable iff (!rst_n) !busy_reg |-> !(cnt_reg > 5'd22);
    endproperty
    a_cnt_zero_idle: assert property (p_cnt_zero_idle) else $error("divider count out of range");

endmodule

// ----- rtl/bitmap_block_allocator.sv -----
// Top level of the bitmap block allocator: sequencer, tag memory, result register.
// Depends on bba_pkg and bba_divider.
//
// Channel  Direction  Handshake          Payload
// cfg      in         cfg_valid/ready    cfg_index, cfg_data
// in       in         in_valid/in_stall  opcode, request_bytes, free_offset
// out      out        out_valid/stall    status, alloc_offset, used_blocks
//
// Init runs two divisions on the shared divider, then one tag memory write per cycle over
// the whole map. Allocate runs a division, a scan of the tag memory, then one write per
// block. Free runs a division, then reads and clears the run of blocks with the freed tag.
// After reset the tag memory is swept to zero, no transfer in.
// A result waits in the output register; while it waits the input is stalled.
`timescale 1ns / 1ps

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [20:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [20:0] request_bytes,
    input  logic [19:0] free_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [19:0] alloc_offset,
    output logic [10:0] used_blocks
);

    localparam int AW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = CW + 1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH,
        S_I_DIV1, S_I_DIV2, S_I_FILL,
        S_A_CHECK, S_A_DIV, S_A_PREV, S_A_PREVW, S_A_RD, S_A_TEST,
        S_A_NEXT, S_A_NEXTW, S_A_TAG, S_A_WRITE,
        S_F_DIV, S_F_RD, S_F_TEST, S_DONE
    } state_t;

    state_t state_reg;

    logic [20:0] region_reg;
    logic [12:0] bsize_reg;
    logic [7:0]  mem [MAX_BLOCKS];
    logic [7:0]  rdata_reg;

    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    logic [CW-1:0] active_reg;
    logic [CW-1:0] used_reg;
    logic [AW-1:0] hint_reg;
    logic [CW-1:0] x_reg, y_reg, steps_reg, ptr_reg, res_reg;
    logic [21:0]   need_reg;
    logic [7:0]    left_reg, right_reg, tag_reg, id_reg;
    logic [1:0]    op_reg;
    logic [20:0]   req_reg;
    logic [19:0]   off_reg;

    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [19:0]   aoff_reg;

    div_req_t      dreq;
    div_rsp_t      drsp;
    logic [21:0]   div_a;
    logic [12:0]   bs_eff;

    logic [33:0]   usedb;
    logic [33:0]   xbs;
    logic [SW-1:0] hint_sum;
    logic [SW-1:0] run_end;

    logic          start_div;
    logic [21:0]   div_a_reg;
    logic          alloc_fail;

    assign bs_eff = (bsize_reg == 13'd0) ? 13'd1 : bsize_reg;

    bba_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        dreq.start    = start_div;
        dreq.dividend = div_a;
        dreq.divisor  = bs_eff;
    end

    assign usedb   = 34'(used_reg) * 34'(bs_eff);
    assign xbs     = 34'(x_reg) * 34'(bs_eff);
    assign run_end = SW'(x_reg) + SW'(y_reg);

    assign alloc_fail = (req_reg == 21'd0) || (active_reg == '0) ||
                        (usedb > 34'(region_reg)) ||
                        (34'(region_reg) - usedb < 34'(req_reg));

    always_comb
    begin
        hint_sum = SW'(x_reg) + SW'(need_reg[CW-1:0]) + SW'(active_reg) - SW'(2);
        if (hint_sum >= SW'(active_reg))
            hint_sum = hint_sum - SW'(active_reg);
        if (hint_sum >= SW'(active_reg))
            hint_sum = hint_sum - SW'(active_reg);
    end

    assign div_a = div_a_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign alloc_offset = aoff_reg;
    assign used_blocks  = 11'(used_reg);

    always_comb
    begin
        we      = 1'b0;
        wr_addr = ptr_reg[AW-1:0];
        wr_data = 8'd0;
        rd_addr = ptr_reg[AW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
            end
            S_I_FILL:
            begin
                we      = 1'b1;
                wr_data = (ptr_reg < res_reg) ? TAG_RESERVED : 8'd0;
            end
            S_A_WRITE:
            begin
                we      = 1'b1;
                wr_data = id_reg;
            end
            S_F_TEST:
            begin
                we = (ptr_reg < active_reg) && (rdata_reg == id_reg) && (id_reg != 8'd0);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            region_reg    <= 21'd16384;
            bsize_reg     <= 13'd16;
            active_reg    <= '0;
            used_reg      <= '0;
            hint_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            start_div     <= 1'b0;
        end
        else
        begin
            start_div <= ((state_reg == S_DISPATCH) &&
                          (op_reg == OP_INIT || op_reg == OP_FREE)) ||
                         ((state_reg == S_I_DIV1) && drsp.done) ||
                         ((state_reg == S_A_CHECK) && !alloc_fail);
            out_valid_reg <= (state_reg == S_DONE) || (out_valid_reg && out_stall);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_REGION)
                    region_reg <= cfg_data;
                else
                    bsize_reg <= cfg_data[12:0];
            end
            case (state_reg)
                S_CLEAR:
                begin
                    ptr_reg <= ptr_reg + CW'(1);
                    if (ptr_reg == CW'(MAX_BLOCKS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        op_reg    <= opcode;
                        req_reg   <= request_bytes;
                        off_reg   <= free_offset;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    aoff_reg <= '0;
                    case (opcode_t'(op_reg))
                        OP_INIT:
                        begin
                            div_a_reg <= {1'b0, region_reg};
                            state_reg <= S_I_DIV1;
                        end
                        OP_ALLOC: state_reg <= S_A_CHECK;
                        OP_FREE:
                        begin
                            div_a_reg <= {2'b0, off_reg};
                            state_reg <= S_F_DIV;
                        end
                        default:
                        begin
                            status_reg <= ST_BADOFF;
                            state_reg  <= S_DONE;
                        end
                    endcase
                end
                S_I_DIV1:
                begin
                    if (drsp.done)
                    begin
                        if (drsp.quotient > 22'(MAX_BLOCKS))
                        begin
                            active_reg <= CW'(MAX_BLOCKS);
                            div_a_reg  <= 22'(MAX_BLOCKS) + 22'(bs_eff) - 22'd1;
                        end
                        else
                        begin
                            active_reg <= drsp.quotient[CW-1:0];
                            div_a_reg  <= drsp.quotient + 22'(bs_eff) - 22'd1;
                        end
                        state_reg <= S_I_DIV2;
                    end
                end
                S_I_DIV2:
                begin
                    if (drsp.done)
                    begin
                        res_reg   <= drsp.quotient[CW-1:0];
                        ptr_reg   <= '0;
                        state_reg <= S_I_FILL;
                    end
                end
                S_I_FILL:
                begin
                    ptr_reg <= ptr_reg + CW'(1);
                    if (ptr_reg == CW'(MAX_BLOCKS - 1))
                    begin
                        used_reg   <= res_reg;
                        hint_reg   <= (res_reg == '0) ? '0 : AW'(res_reg - CW'(1));
                        status_reg <= ST_OK;
                        state_reg  <= S_DONE;
                    end
                end
                S_A_CHECK:
                begin
                    if (alloc_fail)
                    begin
                        status_reg <= ST_NOROOM;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        div_a_reg <= 22'(req_reg) + 22'(bs_eff) - 22'd1;
                        state_reg <= S_A_DIV;
                    end
                end
                S_A_DIV:
                begin
                    if (drsp.done)
                    begin
                        need_reg  <= drsp.quotient;
                        x_reg     <= (CW'(hint_reg) + CW'(1) >= active_reg) ? '0
                                     : CW'(hint_reg) + CW'(1);
                        steps_reg <= '0;
                        state_reg <= S_A_RD;
                    end
                end
                S_A_RD:
                begin
                    if (steps_reg >= active_reg)
                    begin
                        status_reg <= ST_NOROOM;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        ptr_reg   <= x_reg;
                        y_reg     <= '0;
                        state_reg <= S_A_PREV;
                    end
                end
                S_A_PREV:
                begin
                    state_reg <= S_A_PREVW;
                    ptr_reg   <= x_reg;
                end
                S_A_PREVW:
                begin
                    if (run_end >= SW'(active_reg) || 22'(y_reg) >= need_reg ||
                        rdata_reg != 8'd0)
                        state_reg <= S_A_TEST;
                    else
                    begin
                        y_reg     <= y_reg + CW'(1);
                        ptr_reg   <= CW'(run_end + SW'(1));
                        state_reg <= S_A_PREV;
                    end
                end
                S_A_TEST:
                begin
                    if (22'(y_reg) == need_reg)
                    begin
                        ptr_reg   <= (x_reg == '0) ? '0 : x_reg - CW'(1);
                        state_reg <= S_A_NEXT;
                    end
                    else
                    begin
                        steps_reg <= steps_reg + ((y_reg == '0) ? CW'(1) : y_reg);
                        if (SW'(x_reg) + ((y_reg == '0) ? SW'(1) : SW'(y_reg))
                            >= SW'(active_reg))
                            x_reg <= CW'(SW'(x_reg) + ((y_reg == '0) ? SW'(1) : SW'(y_reg))
                                     - SW'(active_reg));
                        else
                            x_reg <= x_reg + ((y_reg == '0) ? CW'(1) : y_reg);
                        state_reg <= S_A_RD;
                    end
                end
                S_A_NEXT:
                begin
                    ptr_reg   <= CW'(run_end);
                    state_reg <= S_A_NEXTW;
                end
                S_A_NEXTW:
                begin
                    left_reg  <= (x_reg == '0) ? 8'd0 : rdata_reg;
                    state_reg <= S_A_TAG;
                end
                S_A_TAG:
                begin
                    right_reg <= (run_end < SW'(active_reg)) ? rdata_reg : 8'd0;
                    tag_reg   <= ((x_reg == '0) ? 8'd0 : left_reg) + 8'd1;
                    id_reg    <= 8'd0;
                    ptr_reg   <= x_reg;
                    state_reg <= S_A_WRITE;
                end
                S_A_WRITE:
                begin
                    if (id_reg == 8'd0)
                    begin
                        if (tag_reg == 8'd0 || tag_reg == right_reg)
                            tag_reg <= tag_reg + 8'd1;
                        else
                            id_reg <= tag_reg;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + CW'(1);
                        if (ptr_reg + CW'(1) == CW'(run_end))
                        begin
                            hint_reg   <= AW'(hint_sum);
                            used_reg   <= used_reg + y_reg;
                            aoff_reg   <= xbs[19:0];
                            status_reg <= ST_OK;
                            state_reg  <= S_DONE;
                        end
                    end
                end
                S_F_DIV:
                begin
                    if (drsp.done)
                    begin
                        if (drsp.quotient >= 22'(active_reg))
                        begin
                            status_reg <= ST_BADOFF;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            ptr_reg   <= drsp.quotient[CW-1:0];
                            id_reg    <= 8'd0;
                            y_reg     <= '0;
                            state_reg <= S_F_RD;
                        end
                    end
                end
                S_F_RD:
                begin
                    state_reg <= S_F_TEST;
                end
                S_F_TEST:
                begin
                    if (id_reg == 8'd0)
                    begin
                        if (rdata_reg == 8'd0)
                        begin
                            status_reg <= ST_BADOFF;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            id_reg    <= rdata_reg;
                            state_reg <= S_F_RD;
                        end
                    end
                    else if (ptr_reg < active_reg && rdata_reg == id_reg)
                    begin
                        y_reg     <= y_reg + CW'(1);
                        ptr_reg   <= ptr_reg + CW'(1);
                        state_reg <= S_F_RD;
                    end
                    else
                    begin
                        used_reg   <= (used_reg > y_reg) ? used_reg - y_reg : '0;
                        status_reg <= ST_OK;
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (status_reg != ST_OK)
                        aoff_reg <= '0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    property p_no_input_busy;
        @(posedge clk) disable iff (!rst_n) state_reg != S_IDLE |-> in_stall;
    endproperty
    a_no_input_busy: assert property (p_no_input_busy) else $error("input taken while busy");

    property p_used_bound;
        @(posedge clk) disable iff (!rst_n) state_reg == S_IDLE |-> used_reg <= CW'(MAX_BLOCKS);
    endproperty
    a_used_bound: assert property (p_used_bound) else $error("used count overflow");

    property p_fail_zero_off;
        @(posedge clk) disable iff (!rst_n)
            out_valid && status != ST_OK |-> alloc_offset == 20'd0;
    endproperty
    a_fail_zero_off: assert property (p_fail_zero_off) else $error("offset on failure");

    property p_hint_range;
        @(posedge clk) disable iff (!rst_n)
            state_reg == S_IDLE && active_reg != '0 |-> CW'(hint_reg) < active_reg;
    endproperty
    a_hint_range: assert property (p_hint_range) else $error("hint out of range");

endmodule
